### rtl/bia_pkg.sv
// bia_pkg: shared constants, types and command format of the bitmap id allocator.
// Used by the channel interfaces and every module of the block; depends on nothing.

package bia_pkg;

    // Bitmap size and the word width of the original map layout
    localparam int NUM_IDS     = 4096;
    localparam int WORD_BITS   = 8;

    // Storage row: a power-of-two group of bits scanned together
    localparam int ROW_BITS    = 2 ** $clog2(8 * WORD_BITS);
    localparam int NUM_ROWS    = (NUM_IDS + ROW_BITS - 1) / ROW_BITS;
    localparam int BIT_AW      = $clog2(ROW_BITS);
    localparam int ROW_AW      = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W       = ROW_AW + BIT_AW;

    // Field widths
    localparam int ID_W        = 16;
    localparam int BASE_W      = 15;
    localparam int DIFF_W      = ID_W + 1;
    localparam logic [BASE_W-1:0] BASE_RESET = 15'd300;

    // Command queue between front and engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    // Classified command: operation and bitmap index (release only)
    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    // Queue status seen by the producer and the consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### rtl/bia_req_if.sv
// bia_req_if: request channel (valid/ready) of the bitmap id allocator.
// Depends on bia_pkg for field widths.

interface bia_req_if;
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [bia_pkg::ID_W-1:0] release_id;

    modport source (output valid, output action, output release_id, input ready);
    modport sink   (input valid, input action, input release_id, output ready);
endinterface

### rtl/bia_rsp_if.sv
// bia_rsp_if: response channel (valid/ready) of the bitmap id allocator.
// Depends on bia_pkg for field widths.

interface bia_rsp_if;
    logic                     valid;
    logic                     ready;
    logic                     granted;
    logic [bia_pkg::ID_W-1:0] allocated_id;

    modport source (output valid, output granted, output allocated_id, input ready);
    modport sink   (input valid, input granted, input allocated_id, output ready);
endinterface

### rtl/bia_front.sv
// bia_front: accepts request transactions, range-checks releases against base_id
// and pushes classified commands into the queue. Depends on bia_pkg, bia_req_if.

module bia_front (
    bia_req_if.sink                      i_req,
    input  logic [bia_pkg::BASE_W-1:0]   i_base_id,
    input  bia_pkg::t_q_status           i_q_status,
    output logic                         o_push,
    output bia_pkg::t_cmd                o_push_cmd
);

    logic [bia_pkg::DIFF_W-1:0] diff;
    logic                       in_range;

    // Offset of the release id from the base; top bit set means below base
    assign diff     = {1'b0, i_req.release_id} - {2'b00, i_base_id};
    assign in_range = !diff[bia_pkg::DIFF_W-1] &&
                      (diff < bia_pkg::DIFF_W'(bia_pkg::NUM_IDS));

    assign i_req.ready = !i_q_status.full;

    // Out-of-range releases are dropped here
    always_comb begin
        o_push_cmd.op  = bia_pkg::t_op'(i_req.action);
        o_push_cmd.idx = diff[bia_pkg::IDX_W-1:0];
        o_push = i_req.valid && !i_q_status.full &&
                 ((o_push_cmd.op == bia_pkg::OP_ALLOC) || in_range);
    end

endmodule

### rtl/bia_cmd_fifo.sv
// bia_cmd_fifo: small command queue decoupling the front from the engine.
// Depends on bia_pkg for the command type and depth.

module bia_cmd_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bia_pkg::t_cmd      i_push_cmd,
    input  logic               i_pop,
    output bia_pkg::t_cmd      o_head,
    output bia_pkg::t_q_status o_status
);

    bia_pkg::t_cmd                 r_entry [bia_pkg::QUEUE_DEPTH];
    logic [bia_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [bia_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [bia_pkg::QCNT_W-1:0]    r_count;
    logic [bia_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [bia_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic                          do_push;
    logic                          do_pop;

    assign o_status.full  = (r_count == bia_pkg::QCNT_W'(bia_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entry[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Pointer wrap
    always_comb begin
        n_wr_ptr = (r_wr_ptr == bia_pkg::QPTR_W'(bia_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == bia_pkg::QPTR_W'(bia_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : r_rd_ptr + 1'b1;
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/bia_engine.sv
// bia_engine: bitmap store and the allocate/release sequencer with result register.
// Depends on bia_pkg and bia_rsp_if.

module bia_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bia_pkg::BASE_W-1:0] i_base_id,
    input  bia_pkg::t_cmd              i_head,
    input  bia_pkg::t_q_status         i_q_status,
    output logic                       o_pop,
    bia_rsp_if.source                  o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EVAL = 2'b10
    } t_state;

    localparam int ROW_BITS = bia_pkg::ROW_BITS;
    localparam int ROW_AW   = bia_pkg::ROW_AW;
    localparam int BIT_AW   = bia_pkg::BIT_AW;
    localparam int IDX_W    = bia_pkg::IDX_W;

    // Bitmap memory, one row per cycle
    logic [ROW_BITS-1:0]   mem [bia_pkg::NUM_ROWS];
    logic [ROW_BITS-1:0]   r_rd_data;
    logic [ROW_AW-1:0]     rd_addr;
    logic                  wr_en;
    logic [ROW_BITS-1:0]   wr_data;

    t_state                r_state;
    t_state                n_state;
    bia_pkg::t_cmd         r_cmd;
    logic [ROW_AW-1:0]     r_row;
    logic [ROW_AW-1:0]     n_row;
    logic [ROW_AW:0]       r_hwm;      // rows at or above are all free
    logic [ROW_AW:0]       n_hwm;
    logic                  r_out_valid;
    logic                  r_granted;
    logic [bia_pkg::ID_W-1:0] r_alloc_id;
    logic                  n_out_valid;
    logic                  n_granted;
    logic [bia_pkg::ID_W-1:0] n_alloc_id;

    logic                  start;
    logic                  row_fresh;
    logic [ROW_BITS-1:0]   row_data;
    logic                  any_free;
    logic [BIT_AW-1:0]     free_pos;
    logic [IDX_W-1:0]      grant_idx;
    logic                  grant_ok;
    logic [ROW_AW:0]       row_next;
    logic [bia_pkg::DIFF_W-1:0] id_sum;

    // A release never blocks; an allocate waits for an empty result register
    assign start = (r_state == S_IDLE) && !i_q_status.empty &&
                   ((i_head.op == bia_pkg::OP_RELEASE) || !r_out_valid);
    assign o_pop = start;

    // Rows never written since reset read as all free
    assign row_fresh = ({1'b0, r_row} >= r_hwm);
    assign row_data  = row_fresh ? '0 : r_rd_data;
    assign row_next  = {1'b0, r_row} + 1'b1;

    // Lowest clear bit of the current row
    always_comb begin
        any_free = 1'b0;
        free_pos = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (!row_data[i]) begin
                any_free = 1'b1;
                free_pos = BIT_AW'(i);
            end
        end
    end

    assign grant_idx = {r_row, free_pos};
    assign grant_ok  = any_free &&
                       ({1'b0, grant_idx} < (IDX_W + 1)'(bia_pkg::NUM_IDS));
    assign id_sum    = {2'b00, i_base_id} + bia_pkg::DIFF_W'(grant_idx);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_hwm       = r_hwm;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_granted   = r_granted;
        n_alloc_id  = r_alloc_id;
        rd_addr     = row_next[ROW_AW-1:0];
        wr_en       = 1'b0;
        wr_data     = row_data;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.op == bia_pkg::OP_ALLOC) begin
                    rd_addr = '0;
                end else begin
                    rd_addr = i_head.idx[IDX_W-1:BIT_AW];
                end
                if (start) begin
                    n_row   = rd_addr;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_cmd.op == bia_pkg::OP_RELEASE) begin
                    // Clear the bit; fresh rows are already clear
                    wr_en   = !row_fresh;
                    wr_data = row_data & ~(ROW_BITS'(1) << r_cmd.idx[BIT_AW-1:0]);
                    n_state = S_IDLE;
                end else if (grant_ok) begin
                    wr_en       = 1'b1;
                    wr_data     = row_data | (ROW_BITS'(1) << free_pos);
                    n_out_valid = 1'b1;
                    n_granted   = 1'b1;
                    n_alloc_id  = id_sum[bia_pkg::ID_W-1:0];
                    if (row_next > r_hwm) begin
                        n_hwm = row_next;
                    end
                    n_state = S_IDLE;
                end else if (any_free ||
                             (r_row == ROW_AW'(bia_pkg::NUM_ROWS - 1))) begin
                    // Only slack bits left, or bitmap exhausted
                    n_out_valid = 1'b1;
                    n_granted   = 1'b0;
                    n_alloc_id  = '0;
                    n_state     = S_IDLE;
                end else begin
                    // Next row read is issued this cycle
                    n_row = row_next[ROW_AW-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Bitmap memory: one write port, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_row] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_granted  <= n_granted;
        r_alloc_id <= n_alloc_id;
        if (start) begin
            r_cmd <= i_head;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hwm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hwm       <= n_hwm;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted      = r_granted;
    assign o_rsp.allocated_id = r_alloc_id;

endmodule

### rtl/bitmap_id_allocator_top.sv
// bitmap_id_allocator_top: top level of the first-free bitmap id allocator.
// Depends on bia_pkg, bia_req_if, bia_rsp_if, bia_front, bia_cmd_fifo, bia_engine.

// Allocates the lowest free id out of NUM_IDS (4096) and returns base_id plus its
// index; releases free an id inside [base_id, base_id + NUM_IDS), others are dropped.
// The bitmap lives in a 64-bit-wide memory scanned one row per cycle; an allocate
// issues its first row read from idle, then scans at most min(rows used + 1, 64) rows,
// all 64 for a full map. A release reads and clears its row and gives no response.
// Rows above the highest row ever written read as free, so no clearing pass is needed
// after reset. Requests land in a 2-entry queue and can be accepted while a response
// waits. base_id (reset 300) must only be written while the block is idle.

module bitmap_id_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bia_pkg::BASE_W-1:0] i_cfg_wdata,
    bia_req_if.sink                    i_req,
    bia_rsp_if.source                  o_rsp
);

    logic [bia_pkg::BASE_W-1:0] r_base_id;
    logic                       push;
    bia_pkg::t_cmd              push_cmd;
    logic                       pop;
    bia_pkg::t_cmd              head;
    bia_pkg::t_q_status         q_status;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_id <= bia_pkg::BASE_RESET;
        end else if (i_cfg_we) begin
            r_base_id <= i_cfg_wdata;
        end
    end

    bia_front u_front (
        .i_req      (i_req),
        .i_base_id  (r_base_id),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_cmd (push_cmd)
    );

    bia_cmd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    bia_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_base_id  (r_base_id),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_rsp      (o_rsp)
    );

endmodule
